>>> src/connection_admission_rate_limiter_macros.svh
// Assertion helpers for the admission limiter checker.
`ifndef CONNECTION_ADMISSION_RATE_LIMITER_MACROS_SVH
`define CONNECTION_ADMISSION_RATE_LIMITER_MACROS_SVH

// Same-cycle implication.
`define CARL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CARL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/carl_pkg.sv
`default_nettype none
package carl_pkg;

  localparam logic [2:0] VERDICT_ADMIT    = 3'd0;
  localparam logic [2:0] VERDICT_CAP      = 3'd1;
  localparam logic [2:0] VERDICT_RATE     = 3'd2;
  localparam logic [2:0] VERDICT_FULL     = 3'd3;
  localparam logic [2:0] VERDICT_RELEASED = 3'd4;

  localparam logic [1:0] REG_CONNECTION_CAP      = 2'd0;
  localparam logic [1:0] REG_ATTEMPTS_PER_WINDOW = 2'd1;
  localparam logic [1:0] REG_WINDOW_TICKS        = 2'd2;

  localparam logic [7:0]  CAP_RESET    = 8'd16;
  localparam logic [3:0]  APW_RESET    = 4'd4;
  localparam logic [31:0] WINDOW_RESET = 32'd60;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_CMP    = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

endpackage
`default_nettype wire

>>> src/connection_admission_rate_limiter.sv
// Connection admission limiter with a sliding-window log per source. One
// transaction at a time: a release goes straight to the output step. An
// attempt walks every table entry, each entry taking an issue step and a
// compare step, repeated once more for every expired timestamp it drops,
// then a decide step and the output step, which loads the result into the
// output register. The next transaction can be taken once the result is
// loaded. The walk is set by the single timestamp memory read port and the
// one 49-bit add-and-compare used for the stale test. in_stall is high from
// acceptance until the result is loaded. The output step waits while an
// older result is still stalled in the output register. A finished result
// waits in the output register while the next transaction is taken in.
`default_nettype none
module connection_admission_rate_limiter
  import carl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int ATTEMPT_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [31:0] source_addr,
  input  wire logic [47:0] now_tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             admitted,
  output logic [2:0]       verdict,
  output logic [7:0]       active_now
);

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HW = (ATTEMPT_DEPTH > 1) ? $clog2(ATTEMPT_DEPTH) : 1;
  localparam int FW = $clog2(ATTEMPT_DEPTH + 1);
  localparam int AW = (TABLE_ENTRIES * ATTEMPT_DEPTH > 1) ?
                      $clog2(TABLE_ENTRIES * ATTEMPT_DEPTH) : 1;

  state_t state;

  logic [7:0]  connection_cap;
  logic [3:0]  attempts_per_window;
  logic [31:0] window_ticks;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [HW-1:0] attempt_head [TABLE_ENTRIES];
  logic [FW-1:0] attempt_fill [TABLE_ENTRIES];
  logic [31:0]   entry_source [TABLE_ENTRIES];
  logic [47:0]   attempt_times [TABLE_ENTRIES * ATTEMPT_DEPTH];
  logic [7:0]    active_total;

  logic [31:0] item_src;
  logic [47:0] item_now;

  logic [EW-1:0] cur;
  logic [31:0]   src_q;
  logic [47:0]   time_q;
  logic          hit_found, free_found;
  logic [EW-1:0] hit_idx, free_idx;

  logic       res_admitted;
  logic [2:0] res_verdict;

  // Stale test without wrap: t + window < now.
  logic [48:0] stale_sum;
  logic        stale;
  assign stale_sum = {1'b0, time_q} + {17'd0, window_ticks};
  assign stale     = stale_sum < {1'b0, item_now};

  logic [HW-1:0] cur_head;
  logic [FW-1:0] cur_fill;
  logic          cur_valid;
  logic [AW-1:0] rd_addr;
  assign cur_head  = attempt_head[cur];
  assign cur_fill  = attempt_fill[cur];
  assign cur_valid = entry_valid[cur];
  assign rd_addr   = AW'(cur) * AW'(ATTEMPT_DEPTH) + AW'(cur_head);

  logic [HW-1:0] head_inc;
  assign head_inc = (cur_head == HW'(ATTEMPT_DEPTH - 1)) ? '0 : cur_head + 1'b1;

  // Decide-stage selection.
  logic [EW-1:0] tgt;
  logic [FW-1:0] sel_fill;
  logic [HW-1:0] sel_head;
  logic [HW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [AW-1:0] wr_addr;
  logic          over_rate;
  assign tgt       = hit_found ? hit_idx : free_idx;
  assign sel_fill  = hit_found ? attempt_fill[hit_idx] : '0;
  assign sel_head  = hit_found ? attempt_head[hit_idx] : '0;
  assign slot_sum  = (HW+1)'(sel_head) + (HW+1)'(sel_fill);
  assign slot      = (slot_sum >= (HW+1)'(ATTEMPT_DEPTH)) ?
                     HW'(slot_sum - (HW+1)'(ATTEMPT_DEPTH)) : HW'(slot_sum);
  assign wr_addr   = AW'(tgt) * AW'(ATTEMPT_DEPTH) + AW'(slot);
  assign over_rate = (8'(sel_fill) >= 8'(attempts_per_window)) ||
                     (8'(sel_fill) >= 8'(ATTEMPT_DEPTH));

  logic admit_ok;
  assign admit_ok = (state == ST_DECIDE) && (active_total < connection_cap) &&
                    !over_rate && (hit_found || free_found);

  // output register can take the result when empty or draining this cycle
  logic load_out;
  assign load_out = (state == ST_FIN) && (!out_valid || !out_stall);

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      connection_cap      <= CAP_RESET;
      attempts_per_window <= APW_RESET;
      window_ticks        <= WINDOW_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_CONNECTION_CAP:      connection_cap      <= cfg_data[7:0];
        REG_ATTEMPTS_PER_WINDOW: attempts_per_window <= cfg_data[3:0];
        REG_WINDOW_TICKS:        window_ticks        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories: one read port each, registered.
  always_ff @(posedge clk) begin
    if (state == ST_ISSUE) begin
      time_q <= attempt_times[rd_addr];
      src_q  <= entry_source[cur];
    end
    if (admit_ok) begin
      attempt_times[wr_addr] <= item_now;
      if (!hit_found) entry_source[tgt] <= item_src;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_src  <= source_addr;
      item_now  <= now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      active_total <= '0;
      out_valid    <= 1'b0;
      cur          <= '0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      hit_idx      <= '0;
      free_idx     <= '0;
      res_admitted <= 1'b0;
      res_verdict  <= VERDICT_ADMIT;
      admitted     <= 1'b0;
      verdict      <= VERDICT_ADMIT;
      active_now   <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        attempt_head[i] <= '0;
        attempt_fill[i] <= '0;
      end
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            if (mode) begin
              if (active_total != 8'd0) active_total <= active_total - 8'd1;
              res_admitted <= 1'b0;
              res_verdict  <= VERDICT_RELEASED;
              state        <= ST_FIN;
            end else begin
              state <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: state <= ST_CMP;
        ST_CMP: begin
          if (cur_valid && cur_fill != '0 && stale) begin
            attempt_head[cur] <= head_inc;
            attempt_fill[cur] <= cur_fill - 1'b1;
            state             <= ST_ISSUE;
          end else begin
            if (!cur_valid || cur_fill == '0) begin
              entry_valid[cur]  <= 1'b0;
              attempt_head[cur] <= '0;
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx   <= cur;
              end
            end else if (!hit_found && src_q == item_src) begin
              hit_found <= 1'b1;
              hit_idx   <= cur;
            end
            if (cur == EW'(TABLE_ENTRIES - 1)) begin
              state <= ST_DECIDE;
            end else begin
              cur   <= cur + 1'b1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_DECIDE: begin
          res_admitted <= admit_ok;
          if (active_total >= connection_cap) begin
            res_verdict <= VERDICT_CAP;
          end else if (over_rate) begin
            res_verdict <= VERDICT_RATE;
          end else if (!hit_found && !free_found) begin
            res_verdict <= VERDICT_FULL;
          end else begin
            res_verdict <= VERDICT_ADMIT;
          end
          if (admit_ok) begin
            entry_valid[tgt] <= 1'b1;
            if (!hit_found) attempt_head[tgt] <= '0;
            attempt_fill[tgt] <= sel_fill + 1'b1;
            active_total      <= active_total + 8'd1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) begin
            admitted   <= res_admitted;
            verdict    <= res_verdict;
            active_now <= active_total;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/carl_checker.sv
`default_nettype none
`include "connection_admission_rate_limiter_macros.svh"
module carl_checker
  import carl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       admitted,
  input wire logic [2:0] verdict,
  input wire logic [7:0] active_now
);

  `CARL_ASSERT_NOW(a_admit_code, out_valid, admitted == (verdict == VERDICT_ADMIT), "admit flag and verdict disagree")
  `CARL_ASSERT_NOW(a_admit_count, out_valid && admitted, active_now != 8'd0, "admitted with zero active count")
  `CARL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "took a second transaction while busy")
  `CARL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind connection_admission_rate_limiter carl_checker u_carl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .admitted   (admitted),
  .verdict    (verdict),
  .active_now (active_now)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import carl_pkg::*;

  localparam int ENTRIES = 16;
  localparam int RING = 8;
  localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_DIRECTED = 12;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic       admitted;
    logic [2:0] verdict;
    logic [7:0] active_now;
  } verdict_rec_t;

  typedef struct packed {
    logic         mode;
    logic [31:0]  source_addr;
    logic [47:0]  now_tick;
    logic         typed;
    verdict_rec_t res;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  cap;
    logic [3:0]  apw;
    logic [31:0] window;
  } limits_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [1:0] cfg_index = REG_CONNECTION_CAP;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [31:0] source_addr = '0;
  logic [47:0] now_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic admitted;
  logic [2:0] verdict;
  logic [7:0] active_now;

  // limiter shadow state
  logic [7:0]  cap_q;
  logic [3:0]  apw_q;
  logic [31:0] window_q;
  logic        src_used [ENTRIES];
  logic [31:0] src_addr [ENTRIES];
  logic [47:0] stamp [ENTRIES][RING];
  logic [2:0]  ring_head [ENTRIES];
  logic [3:0]  ring_fill [ENTRIES];
  logic [7:0]  conn_count;

  // expected results in order of acceptance
  verdict_rec_t expect_fifo [EXP_DEPTH];
  int expect_wr = 0;
  int expect_rd = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  logic [47:0] clock_tick = '0;
  logic [31:0] addr_pool [20];

  always #5 clk = ~clk;

  connection_admission_rate_limiter dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .source_addr(source_addr), .now_tick(now_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .admitted(admitted), .verdict(verdict), .active_now(active_now)
  );

  function automatic verdict_rec_t admit_decision(logic m, logic [31:0] src, logic [47:0] t);
    verdict_rec_t r;
    int hit;
    int free_e;
    int e;
    logic [3:0] fill;
    logic [48:0] limit;
    r = '0;
    hit = -1;
    free_e = -1;
    if (m) begin
      if (conn_count != 8'd0) conn_count = conn_count - 8'd1;
      r.verdict = VERDICT_RELEASED;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (src_used[i]) begin
          while (ring_fill[i] != 4'd0) begin
            limit = {1'b0, stamp[i][ring_head[i]]} + {17'b0, window_q};
            if (limit < {1'b0, t}) begin
              ring_head[i] = ring_head[i] + 3'd1;
              ring_fill[i] = ring_fill[i] - 4'd1;
            end else break;
          end
          if (ring_fill[i] == 4'd0) begin
            src_used[i] = 1'b0;
            ring_head[i] = '0;
          end
        end
      end
      if (conn_count >= cap_q) begin
        r.verdict = VERDICT_CAP;
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (src_used[i]) begin
            if (hit < 0 && src_addr[i] == src) hit = i;
          end else if (free_e < 0) begin
            free_e = i;
          end
        end
        fill = (hit >= 0) ? ring_fill[hit] : 4'd0;
        if (fill >= apw_q || fill >= RING) begin
          r.verdict = VERDICT_RATE;
        end else if (hit < 0 && free_e < 0) begin
          r.verdict = VERDICT_FULL;
        end else begin
          e = (hit >= 0) ? hit : free_e;
          if (hit < 0) begin
            src_used[e] = 1'b1;
            src_addr[e] = src;
            ring_head[e] = '0;
            ring_fill[e] = '0;
          end
          stamp[e][3'(ring_head[e] + ring_fill[e])] = t;
          ring_fill[e] = ring_fill[e] + 4'd1;
          conn_count = conn_count + 8'd1;
          r.admitted = 1'b1;
          r.verdict = VERDICT_ADMIT;
        end
      end
    end
    r.active_now = conn_count;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_CONNECTION_CAP:      cap_q = val[7:0];
      REG_ATTEMPTS_PER_WINDOW: apw_q = val[3:0];
      default:                 window_q = val;
    endcase
  endtask

  // drives one transaction; in_valid stays high until a gap is taken
  task automatic send(logic m, logic [31:0] src, logic [47:0] t, logic typed,
                      verdict_rec_t typed_res);
    verdict_rec_t r;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    source_addr <= src;
    now_tick <= t;
    do @(posedge clk); while (in_stall);
    r = admit_decision(m, src, t);
    expect_fifo[expect_wr % EXP_DEPTH] = typed ? typed_res : r;
    expect_wr++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expect_wr != expect_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expect_wr == expect_rd) begin
        $display("%0t: unexpected transaction adm=%0d verdict=%0d active=%0d",
                 $time, admitted, verdict, active_now);
        errors++;
      end else begin
        verdict_rec_t x;
        x = expect_fifo[expect_rd % EXP_DEPTH];
        expect_rd++;
        if (x.admitted !== admitted) begin
          $display("%0t: admitted expected %0d actual %0d", $time, x.admitted, admitted);
          errors++;
        end
        if (x.verdict !== verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, x.verdict, verdict);
          errors++;
        end
        if (x.active_now !== active_now) begin
          $display("%0t: active_now expected %0d actual %0d", $time, x.active_now,
                   active_now);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [N_DIRECTED];
    limits_t phases [N_PHASES];
    logic m;
    logic [31:0] src;
    logic [63:0] step;
    int r;
    rows = '{
      '{1'b1, 32'h0, 48'd0, 1'b1, '{1'b0, VERDICT_RELEASED, 8'd0}},
      '{1'b0, 32'h0, 48'd0, 1'b1, '{1'b1, VERDICT_ADMIT, 8'd1}},
      '{1'b0, 32'h0, 48'd1, 1'b1, '{1'b1, VERDICT_ADMIT, 8'd2}},
      '{1'b0, 32'h0, 48'd2, 1'b1, '{1'b1, VERDICT_ADMIT, 8'd3}},
      '{1'b0, 32'h0, 48'd3, 1'b1, '{1'b1, VERDICT_ADMIT, 8'd4}},
      '{1'b0, 32'h0, 48'd4, 1'b1, '{1'b0, VERDICT_RATE, 8'd4}},
      '{1'b0, 32'hFFFF_FFFF, 48'd10, 1'b1, '{1'b1, VERDICT_ADMIT, 8'd5}},
      '{1'b1, 32'hFFFF_FFFF, 48'd10, 1'b1, '{1'b0, VERDICT_RELEASED, 8'd4}},
      '{1'b0, 32'h0, 48'd62, 1'b0, '0},  // oldest two stamps expire
      '{1'b0, 32'h0, 48'd62, 1'b0, '0},
      '{1'b0, 32'h0, 48'd63, 1'b0, '0},
      '{1'b0, 32'h5555_AAAA, 48'd200, 1'b0, '0}
    };
    // cap, per-window limit, window
    phases = '{
      '{8'd16, 4'd4, 32'd60},
      '{8'd255, 4'd8, 32'd1000},
      '{8'd3, 4'd2, 32'd20},
      '{8'd255, 4'd1, 32'd0},
      '{8'd0, 4'd4, 32'd60},
      '{8'd255, 4'd0, 32'd60},
      '{8'd255, 4'd15, 32'd40},
      '{8'd200, 4'd8, 32'hFFFF_FFFF}
    };
    cap_q = CAP_RESET;
    apw_q = APW_RESET;
    window_q = WINDOW_RESET;
    conn_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      src_used[i] = 1'b0;
      ring_head[i] = '0;
      ring_fill[i] = '0;
    end
    for (int i = 0; i < 20; i++) addr_pool[i] = $urandom();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].mode, rows[i].source_addr, rows[i].now_tick, rows[i].typed, rows[i].res);
      clock_tick = rows[i].now_tick;
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_CONNECTION_CAP, {24'h0, phases[p].cap});
      write_reg(REG_ATTEMPTS_PER_WINDOW, {28'h0, phases[p].apw});
      write_reg(REG_WINDOW_TICKS, phases[p].window);
      if (p == N_PHASES - 1) clock_tick = TICK_MAX - 48'd20000;
      calm = (p == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 60) step = 64'($urandom_range(0, 3));
        else if (r < 90)
          step = 64'($urandom_range(0, (window_q >> 2) > 32'd500 ? 32'd500 : window_q >> 2));
        else step = 64'($urandom_range(0, window_q > 32'd5000 ? 32'd10000
                                                               : 32'd2 * window_q + 32'd5));
        clock_tick = (64'(clock_tick) + step > 64'(TICK_MAX)) ? TICK_MAX
                                                             : clock_tick + step[47:0];
        m = ($urandom_range(0, 99) < 25);
        src = ($urandom_range(0, 99) < 70) ? addr_pool[$urandom_range(0, 19)] : $urandom();
        send(m, src, clock_tick, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/carl_pkg.sv
src/connection_admission_rate_limiter.sv
src/carl_checker.sv
sim/testbench.sv
